>>> rtl/core/tlpt_pkg.sv
// Shared constants and codes for the two-level page table engine.
package tlpt_pkg;

  // Fixed geometry of the address split.
  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = 10;
  localparam int VA_W          = 32;
  localparam int FRAME_W       = 20;
  localparam int FLAGS_W       = 12;
  localparam int PTE_W         = FRAME_W + FLAGS_W;

  // Stream payload widths.
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 24;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_MAP    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNMAP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TABLE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

endpackage

>>> rtl/core/tlpt_ram.sv
// Generic single-port synchronous RAM with a registered read.
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, otherwise read; the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/two_level_page_table_engine.sv
// Top level of the two-level page table engine: walk control and both memories.
//
//  Channel | Dir | Handshake           | Payload
//  --------+-----+---------------------+------------------------------------------
//  in      | in  | in_tvalid/in_tready | tuser kind; tdata va, frame, flags
//  out     | out | out_tvalid/out_tready | tuser status; tdata found_frame
//
// A walk does one directory read, then a table write (map, unmap) or a table
// read (lookup), then the result register load.
// A map that links a new table sweeps its 1024 entries, one write a cycle.
// After reset the directory's 1024 entries are cleared; in_tready stays low.
// A result waits in the output register while the next beat is accepted; a
// walk that finishes while that register is still full holds until it drains.
module two_level_page_table_engine #(
  parameter int MAX_TABLES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tlpt_pkg::KIND_W-1:0]       in_tuser,   // [1:0] kind
  input  logic [tlpt_pkg::IN_DATA_W-1:0]    in_tdata,   // [31:0] virt_addr,
                                                        // [51:32] phys_frame,
                                                        // [63:52] page_flags
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tlpt_pkg::STATUS_W-1:0]     out_tuser,  // [1:0] status
  output logic [tlpt_pkg::OUT_DATA_W-1:0]   out_tdata   // [19:0] found_frame,
                                                        // [23:20] zero
);
  import tlpt_pkg::*;

  localparam int TBL_W    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int CNT_W    = $clog2(MAX_TABLES + 1);
  localparam int DIR_W    = TBL_W + 1;
  localparam int TS_DEPTH = MAX_TABLES * TABLE_ENTRIES;
  localparam int TS_AW    = $clog2(TS_DEPTH);
  localparam int DIR_AW   = $clog2(DIR_ENTRIES);

  // Walk states.
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIR  = 3'd2;
  localparam logic [2:0] S_TBL  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    pool_r, pool_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [DIR_AW-1:0]   di_r, di_nxt;
  logic [IDX_W-1:0]    ti_r, ti_nxt;
  logic [PTE_W-1:0]    pte_r, pte_nxt;
  logic [TBL_W-1:0]    tbl_r, tbl_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]  res_frame_r, res_frame_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]  out_frame_r, out_frame_nxt;

  logic                dir_we;
  logic [DIR_AW-1:0]   dir_addr;
  logic [DIR_W-1:0]    dir_wdata;
  logic [DIR_W-1:0]    dir_rdata;
  logic                ts_we;
  logic [TS_AW-1:0]    ts_addr;
  logic [PTE_W-1:0]    ts_wdata;
  logic [PTE_W-1:0]    ts_rdata;

  logic                dir_present;
  logic [TBL_W-1:0]    dir_tbl;
  logic [TBL_W-1:0]    new_tbl;
  logic                cnt_last;

  assign dir_present = dir_rdata[DIR_W-1];
  assign dir_tbl     = dir_rdata[TBL_W-1:0];
  assign new_tbl     = pool_r[TBL_W-1:0];
  assign cnt_last    = (cnt_r == {IDX_W{1'b1}});

  // Directory: a present bit over the table number.
  tlpt_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  // Second-level tables, one after another; an entry is {frame, flags}.
  tlpt_ram #(
    .WIDTH (PTE_W),
    .DEPTH (TS_DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .we    (ts_we),
    .addr  (ts_addr),
    .wdata (ts_wdata),
    .rdata (ts_rdata)
  );

  // Walk sequencer and memory port control.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pool_nxt       = pool_r;
    kind_nxt       = kind_r;
    di_nxt         = di_r;
    ti_nxt         = ti_r;
    pte_nxt        = pte_r;
    tbl_nxt        = tbl_r;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    dir_we         = 1'b0;
    dir_addr       = di_r;
    dir_wdata      = '0;
    ts_we          = 1'b0;
    ts_addr        = TS_AW'({dir_tbl, ti_r});
    ts_wdata       = '0;

    // The output register drains whenever its beat is taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        dir_we   = 1'b1;
        dir_addr = cnt_r;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        dir_addr = in_tdata[VA_W-1 -: DIR_AW];
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          di_nxt    = in_tdata[VA_W-1 -: DIR_AW];
          ti_nxt    = in_tdata[VA_W-DIR_AW-1 -: IDX_W];
          pte_nxt   = {in_tdata[VA_W +: FRAME_W], in_tdata[VA_W+FRAME_W +: FLAGS_W]};
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        res_status_nxt = ST_OK;
        res_frame_nxt  = '0;
        state_nxt      = S_RESP;
        case (kind_r)
          KIND_MAP: begin
            if (dir_present) begin
              ts_we    = 1'b1;
              ts_wdata = pte_r;
            end else if (pool_r < CNT_W'(MAX_TABLES)) begin
              // Link a fresh table; the sweep clears it and writes the entry.
              dir_we    = 1'b1;
              dir_wdata = {1'b1, new_tbl};
              tbl_nxt   = new_tbl;
              pool_nxt  = pool_r + 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_CLR;
            end else begin
              res_status_nxt = ST_EXHAUSTED;
            end
          end
          KIND_UNMAP: begin
            if (dir_present) begin
              ts_we = 1'b1;
            end else begin
              res_status_nxt = ST_NO_TABLE;
            end
          end
          KIND_LOOKUP: begin
            if (dir_present) begin
              state_nxt = S_TBL;
            end else begin
              res_status_nxt = ST_NO_TABLE;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end
      S_TBL: begin
        if (ts_rdata == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          res_frame_nxt = ts_rdata[PTE_W-1 -: FRAME_W];
        end
        state_nxt = S_RESP;
      end
      S_CLR: begin
        // The sweep writes the new entry in its own slot and zero elsewhere.
        ts_we    = 1'b1;
        ts_addr  = TS_AW'({tbl_r, cnt_r});
        ts_wdata = (cnt_r == ti_r) ? pte_r : '0;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_frame_nxt  = res_frame_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      pool_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pool_r      <= pool_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    di_r         <= di_nxt;
    ti_r         <= ti_nxt;
    pte_r        <= pte_nxt;
    tbl_r        <= tbl_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W-FRAME_W){1'b0}}, out_frame_r};

  // No result leaves while the directory is still being cleared.
  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !out_tvalid)
    else $error("result beat during directory clear");

  // The table pool never hands out more tables than it holds.
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pool_r <= CNT_W'(MAX_TABLES))
    else $error("table pool overrun");

  // Exhaustion is reported only once every table is in use.
  a_exhausted_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_EXHAUSTED)) |-> (pool_r == CNT_W'(MAX_TABLES)))
    else $error("exhausted status with tables left");

  // Only a successful lookup carries a frame number.
  a_frame_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata == '0))
    else $error("frame reported with a failing status");

endmodule
